// ===== design/lsc_pkg.sv =====
// Shared types and constants of the link sequence controller.
`default_nettype none

package lsc_pkg;

  // Event kinds carried with each input transaction.
  typedef enum logic [1:0] {
    OP_SEND_REQ = 2'd0,
    OP_TICK     = 2'd1,
    OP_RESTART  = 2'd2,
    OP_REPORT   = 2'd3
  } op_t;

  // Commands issued by the sequencer.
  typedef enum logic [2:0] {
    ACT_SEND_DATA  = 3'd0,
    ACT_SEND_IDLE  = 3'd1,
    ACT_POST_RX    = 3'd2,
    ACT_LINE_RESET = 3'd3,
    ACT_DELIVER    = 3'd4,
    ACT_FREE_TX    = 3'd5
  } action_t;

  // Cause of a line reset.
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_SEQUENCE = 2'd1,
    ERR_FATAL    = 2'd2,
    ERR_UNKNOWN  = 2'd3
  } err_t;

  // Device report kinds.
  localparam logic [2:0] RTYPE_TX   = 3'd0;
  localparam logic [2:0] RTYPE_CTRL = 3'd1;
  localparam logic [2:0] RTYPE_RX   = 3'd4;

  // Control words.
  localparam logic [15:0] CTRL_OVERRUN    = 16'o4;
  localparam logic [15:0] CTRL_FATAL_MASK = 16'o1772;

  // Register reset values and byte addresses.
  localparam logic [7:0] IDLE_LIMIT_RESET = 8'd10;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_IDLE_LIMIT    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_FORCE_OVERRUN = 3'd4;

  // Result queue depth; one event can add two entries.
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] idle_limit;
    logic       force_overrun;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic        queue_nonempty;
    logic        free_buffer_ok;
    logic        report_ready;
    logic [2:0]  report_type;
    logic        rx_is_data;
    logic [7:0]  rx_seq;
    logic [15:0] control_code;
  } item_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  packet_seq;
    err_t        error_kind;
    logic [7:0]  expected_seq;
    logic        link_up;
    logic [15:0] overrun_total;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ===== design/lsc_engine.sv =====
// Sequencer state and the update that one event makes to it.
`default_nettype none

module lsc_engine #(
  parameter int unsigned SEQ_WIDTH = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire lsc_pkg::cfg_t   cfg,
  input  wire logic            item_valid,
  input  wire lsc_pkg::item_t  item,
  output logic [1:0]           res_count,
  output lsc_pkg::result_t     res0,
  output lsc_pkg::result_t     res1
);
  import lsc_pkg::*;

  logic                 tx_busy, tx_busy_next;
  logic                 rx_posted, rx_posted_next;
  logic [SEQ_WIDTH-1:0] tx_seq, tx_seq_next;
  logic [SEQ_WIDTH-1:0] rx_seq, rx_seq_next;
  logic [7:0]           idle_ticks, idle_ticks_next;
  logic                 up_flag, up_flag_next;
  logic                 rx_held, rx_held_next;
  logic                 tx_held, tx_held_next;
  logic [15:0]          overrun_count, overrun_count_next;
  logic [7:0]           spurious_count, spurious_count_next;

  logic [SEQ_WIDTH+7:0] rx_seq_ext;
  logic [SEQ_WIDTH-1:0] rseq;
  logic [SEQ_WIDTH+7:0] tx_seq_ext;
  logic [SEQ_WIDTH+7:0] rx_exp_ext;

  action_t    a0_action, a1_action;
  logic [7:0] a0_seq, a1_seq;
  err_t       a0_err;
  logic [7:0] a0_exp;
  logic [1:0] cnt;
  logic       restart;

  // Received numbers are compared on their low SEQ_WIDTH bits; outgoing
  // numbers are presented on eight bits.
  assign rx_seq_ext = {{SEQ_WIDTH{1'b0}}, item.rx_seq};
  assign rseq       = rx_seq_ext[SEQ_WIDTH-1:0];
  assign tx_seq_ext = {8'd0, tx_seq};
  assign rx_exp_ext = {8'd0, rx_seq};

  always_comb begin
    tx_busy_next        = tx_busy;
    rx_posted_next      = rx_posted;
    tx_seq_next         = tx_seq;
    rx_seq_next         = rx_seq;
    idle_ticks_next     = idle_ticks;
    up_flag_next        = up_flag;
    rx_held_next        = rx_held;
    tx_held_next        = tx_held;
    overrun_count_next  = overrun_count;
    spurious_count_next = spurious_count;
    a0_action = ACT_SEND_DATA;
    a1_action = ACT_SEND_DATA;
    a0_seq    = 8'd0;
    a1_seq    = 8'd0;
    a0_err    = ERR_NONE;
    a0_exp    = 8'd0;
    cnt       = 2'd0;
    restart   = 1'b0;

    unique case (item.op)
      OP_SEND_REQ: begin
        if (!tx_busy && item.queue_nonempty) begin
          tx_busy_next = 1'b1;
          tx_held_next = 1'b1;
          tx_seq_next  = tx_seq + SEQ_WIDTH'(1);
          a0_action    = ACT_SEND_DATA;
          a0_seq       = tx_seq_ext[7:0];
          cnt          = 2'd1;
        end
      end
      OP_TICK: begin
        if (!tx_busy) begin
          if (idle_ticks != 8'hFF) begin
            idle_ticks_next = idle_ticks + 8'd1;
          end
          if (idle_ticks >= cfg.idle_limit) begin
            tx_busy_next = 1'b1;
            a0_action    = ACT_SEND_IDLE;
            cnt          = 2'd1;
          end
        end
      end
      OP_RESTART: begin
        restart   = 1'b1;
        a0_action = ACT_LINE_RESET;
        a0_err    = ERR_NONE;
        cnt       = 2'd1;
      end
      OP_REPORT: begin
        priority if (!item.report_ready) begin
          if (spurious_count != 8'hFF) begin
            spurious_count_next = spurious_count + 8'd1;
          end
        end else if (item.report_type == RTYPE_RX) begin
          up_flag_next = 1'b1;
          if (item.rx_is_data) begin
            rx_seq_next = rx_seq + SEQ_WIDTH'(1);
            if (rseq != rx_seq) begin
              restart   = 1'b1;
              a0_action = ACT_LINE_RESET;
              a0_err    = ERR_SEQUENCE;
              a0_exp    = rx_exp_ext[7:0];
              cnt       = 2'd1;
            end else begin
              a0_action      = ACT_DELIVER;
              rx_held_next   = item.free_buffer_ok;
              rx_posted_next = item.free_buffer_ok && !cfg.force_overrun;
              a1_action      = ACT_POST_RX;
              cnt            = rx_posted_next ? 2'd2 : 2'd1;
            end
          end else begin
            rx_posted_next = rx_held && !cfg.force_overrun;
            a0_action      = ACT_POST_RX;
            cnt            = rx_posted_next ? 2'd1 : 2'd0;
          end
        end else if (item.report_type == RTYPE_TX) begin
          if (tx_busy) begin
            idle_ticks_next = 8'd0;
            tx_busy_next    = item.queue_nonempty;
            tx_held_next    = item.queue_nonempty;
            if (item.queue_nonempty) begin
              tx_seq_next = tx_seq + SEQ_WIDTH'(1);
            end
            // A freed buffer comes before the next data packet.
            if (tx_held) begin
              a0_action = ACT_FREE_TX;
              a1_action = ACT_SEND_DATA;
              a1_seq    = tx_seq_ext[7:0];
              cnt       = item.queue_nonempty ? 2'd2 : 2'd1;
            end else begin
              a0_action = ACT_SEND_DATA;
              a0_seq    = tx_seq_ext[7:0];
              cnt       = item.queue_nonempty ? 2'd1 : 2'd0;
            end
          end
        end else if (item.report_type == RTYPE_CTRL) begin
          if (item.control_code == CTRL_OVERRUN) begin
            if (overrun_count != 16'hFFFF) begin
              overrun_count_next = overrun_count + 16'd1;
            end
            if (!rx_posted) begin
              rx_held_next   = rx_held || item.free_buffer_ok;
              rx_posted_next = rx_held_next && !cfg.force_overrun;
              a0_action      = ACT_POST_RX;
              cnt            = rx_posted_next ? 2'd1 : 2'd0;
            end
          end else if ((item.control_code & CTRL_FATAL_MASK) != 16'd0) begin
            restart   = 1'b1;
            a0_action = ACT_LINE_RESET;
            a0_err    = ERR_FATAL;
            cnt       = 2'd1;
          end
        end else begin
          restart   = 1'b1;
          a0_action = ACT_LINE_RESET;
          a0_err    = ERR_UNKNOWN;
          cnt       = 2'd1;
        end
      end
      default: begin
      end
    endcase

    // A line restart is always the final step of an event.
    if (restart) begin
      up_flag_next    = 1'b0;
      tx_busy_next    = 1'b0;
      tx_seq_next     = '0;
      rx_seq_next     = '0;
      rx_posted_next  = 1'b0;
      idle_ticks_next = 8'd0;
      tx_held_next    = 1'b0;
    end
  end

  always_comb begin
    res_count = item_valid ? cnt : 2'd0;

    res0.action        = a0_action;
    res0.packet_seq    = a0_seq;
    res0.error_kind    = a0_err;
    res0.expected_seq  = a0_exp;
    res0.link_up       = up_flag_next;
    res0.overrun_total = overrun_count_next;
    res0.last          = (cnt == 2'd1);

    res1.action        = a1_action;
    res1.packet_seq    = a1_seq;
    res1.error_kind    = ERR_NONE;
    res1.expected_seq  = 8'd0;
    res1.link_up       = up_flag_next;
    res1.overrun_total = overrun_count_next;
    res1.last          = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_busy        <= 1'b0;
      rx_posted      <= 1'b0;
      tx_seq         <= '0;
      rx_seq         <= '0;
      idle_ticks     <= 8'd0;
      up_flag        <= 1'b0;
      rx_held        <= 1'b0;
      tx_held        <= 1'b0;
      overrun_count  <= 16'd0;
      spurious_count <= 8'd0;
    end else if (item_valid) begin
      tx_busy        <= tx_busy_next;
      rx_posted      <= rx_posted_next;
      tx_seq         <= tx_seq_next;
      rx_seq         <= rx_seq_next;
      idle_ticks     <= idle_ticks_next;
      up_flag        <= up_flag_next;
      rx_held        <= rx_held_next;
      tx_held        <= tx_held_next;
      overrun_count  <= overrun_count_next;
      spurious_count <= spurious_count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_reset_clears_link: assert property (@(posedge clk) disable iff (rst)
    (item_valid && res_count != 2'd0 && res0.action == ACT_LINE_RESET)
    |=> (!tx_busy && !up_flag && tx_seq == '0 && rx_seq == '0))
    else $error("line reset left link state behind");

  a_busy_tick_holds: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item.op == OP_TICK && tx_busy) |=> $stable(idle_ticks))
    else $error("idle counter moved while transmit busy");

  a_send_advances_seq: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item.op == OP_SEND_REQ && res_count == 2'd1)
    |=> (tx_seq == $past(tx_seq) + SEQ_WIDTH'(1) && tx_busy))
    else $error("data send did not advance the transmit sequence");
`endif

endmodule

`default_nettype wire

// ===== design/lsc_result_queue.sv =====
// Small result queue that takes up to two results a cycle and gives one while the output is ready.
`default_nettype none

module lsc_result_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        push_count,
  input  wire lsc_pkg::result_t  push0,
  input  wire lsc_pkg::result_t  push1,
  output logic                   room2,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lsc_pkg::result_t       out_data
);
  import lsc_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  result_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W-1:0]   wr_ptr1;
  logic [CNT_W-1:0]   count, count_next;
  logic               pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign room2     = (count <= CNT_W'(QUEUE_DEPTH - 2));
  assign wr_ptr1   = wr_ptr + PTR_W'(1);
  assign count_next = count + CNT_W'(push_count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push_count != 2'd0) |-> (count + CNT_W'(push_count) <= CNT_W'(QUEUE_DEPTH)))
    else $error("result queue overflow");

  a_pair_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push_count == 2'd2) |-> room2)
    else $error("two results pushed without room");
`endif

endmodule

`default_nettype wire

// ===== design/link_sequence_controller.sv =====
// Top level of the link sequence controller: ports, registers, input stage.
`default_nettype none

// Channel   Direction  Transaction
// s_axis    in         one event: tuser = op, tdata = event fields
// m_axis    out        one command: tuser = action, tlast = final command of an event
// apb       in/out     register access: idle_limit at 0x0, force_overrun at 0x4
//
// An accepted event sits in the input register, where the engine
// updates the link state and writes zero, one or two commands into a
// four-entry result queue. An event leaves the input register only when the
// queue has room for two commands, so one event a cycle is sustained while
// events give at most one command each and the output side keeps taking them.
// Reset (rst, synchronous, active high) clears the link state, the counts,
// the queue and the registers to idle_limit 10 and force_overrun 0.
// The event side stalls only while the queue lacks room for two commands.

module link_sequence_controller #(
  parameter int unsigned SEQ_WIDTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Event input.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] queue_nonempty, [1] free_buffer_ok, [2] report_ready, [5:3] report_type,
  // [6] rx_is_data, [14:7] rx_seq, [30:15] control_code, [31] zero
  input  wire logic [31:0] s_axis_tdata,
  // [1:0] op
  input  wire logic [1:0]  s_axis_tuser,
  // Command output.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] packet_seq, [9:8] error_kind, [17:10] expected_seq, [18] link_up,
  // [34:19] overrun_total, [39:35] zero
  output logic [39:0]      m_axis_tdata,
  // [2:0] action
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lsc_pkg::*;

  cfg_t       cfg;
  logic       cfg_write;

  logic       in_valid;
  item_t      in_item;
  item_t      s_item;
  logic       room2;
  logic       fire;

  logic [1:0] res_count;
  result_t    res0, res1;
  result_t    out_res;

  // Registers are decoded on paddr[2]; the low address bits are ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_limit    <= IDLE_LIMIT_RESET;
      cfg.force_overrun <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == ADDR_FORCE_OVERRUN[2]) begin
        cfg.force_overrun <= pwdata[0];
      end else begin
        cfg.idle_limit <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ADDR_FORCE_OVERRUN[2]) begin
      prdata = {31'd0, cfg.force_overrun};
    end else begin
      prdata = {24'd0, cfg.idle_limit};
    end
  end

  // Unpack the event transaction.
  always_comb begin
    s_item.op             = op_t'(s_axis_tuser);
    s_item.queue_nonempty = s_axis_tdata[0];
    s_item.free_buffer_ok = s_axis_tdata[1];
    s_item.report_ready   = s_axis_tdata[2];
    s_item.report_type    = s_axis_tdata[5:3];
    s_item.rx_is_data     = s_axis_tdata[6];
    s_item.rx_seq         = s_axis_tdata[14:7];
    s_item.control_code   = s_axis_tdata[30:15];
  end

  // The input register is processed once the queue can absorb a full pair of
  // commands; a new event may enter in the same cycle.
  assign fire          = in_valid && room2;
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= s_item;
    end
  end

  lsc_engine #(
    .SEQ_WIDTH (SEQ_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (fire),
    .item       (in_item),
    .res_count  (res_count),
    .res0       (res0),
    .res1       (res1)
  );

  lsc_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (res_count),
    .push0      (res0),
    .push1      (res1),
    .room2      (room2),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_res)
  );

  // Pack the command transaction.
  assign m_axis_tuser = out_res.action;
  assign m_axis_tlast = out_res.last;
  assign m_axis_tdata = {5'd0, out_res.overrun_total, out_res.link_up,
                         out_res.expected_seq, out_res.error_kind, out_res.packet_seq};

endmodule

`default_nettype wire
